// File: hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// Cosine series package
// Shared constants, fixed-point formats and the sequencer state type for the
// cosine Maclaurin series block.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Default configuration of the top level
  localparam int unsigned MAX_TERMS_DEF     = 16;
  localparam int unsigned ACC_FRAC_BITS_DEF = 30;

  // Angle input: signed Q16.16
  localparam int unsigned ANGLE_W    = 32;
  localparam int unsigned ANGLE_FRAC = 16;

  // Range reduction: |angle| in Q32 modulo 2*pi
  localparam int unsigned RED_W     = ANGLE_W + ANGLE_FRAC;
  localparam int unsigned RED_FRAC  = 32;
  localparam int unsigned RED_OUT_W = 35;
  localparam int unsigned RED_STEPS = 14;
  localparam logic [RED_OUT_W-1:0] TWO_PI_Q32 = 35'h6_487E_D511;

  // Tolerance register, unsigned Q1.30
  localparam int unsigned TOL_W    = 31;
  localparam int unsigned TOL_FRAC = 30;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd107374;

  // Integer bits above the accumulator fraction for each quantity
  localparam int unsigned X_IW    = 3;   // x < 2*pi
  localparam int unsigned X2_IW   = 6;   // x^2 < 4*pi^2
  localparam int unsigned TERM_IW = 8;   // largest term stays below 128
  localparam int unsigned PROD_IW = TERM_IW + X2_IW;
  localparam int unsigned SUM_IW  = 9;   // signed partial sums stay below 128

  // Multiplier digit and divider bits per cycle
  localparam int unsigned DIG_W    = 16;
  localparam int unsigned DIV_BITS = 4;

  // Result format
  localparam int unsigned COS_W    = 32;
  localparam int unsigned OUT_FRAC = 30;
  localparam int unsigned TERMS_W  = 6;
  localparam logic [COS_W-1:0] COS_MAX = 32'h7FFF_FFFF;
  localparam logic [COS_W-1:0] COS_MIN = 32'h8000_0000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_SQR,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } cst_state_e;

endpackage

// File: hw/rtl/cst_red.sv
// ----------------------------------------------------------------------------
// Angle range reduction
// Reduces a Q16.16 magnitude modulo 2*pi in Q32 by restoring subtraction of
// a right-shifting multiple of 2*pi, one compare and subtract per cycle.
// ----------------------------------------------------------------------------
module cst_red import cst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ANGLE_W-1:0]   mag_i,
  output logic                 done_o,
  output logic [RED_OUT_W-1:0] red_o
);

  localparam int unsigned C_W = $clog2(RED_STEPS);

  logic           run_q;
  logic           done_q;
  logic [C_W-1:0] cnt_q;
  logic [RED_W-1:0] rem_q;
  logic [RED_W-1:0] dsh_q;
  logic [RED_W-1:0] rem_nx;

  // Subtract the current multiple of 2*pi when it fits
  always_comb begin
    if (rem_q >= dsh_q) begin
      rem_nx = rem_q - dsh_q;
    end else begin
      rem_nx = rem_q;
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == C_W'(RED_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load the widened magnitude, then advance the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {mag_i, {ANGLE_FRAC{1'b0}}};
      dsh_q <= RED_W'(TWO_PI_Q32) << (RED_STEPS - 1);
    end else if (run_q) begin
      rem_q <= rem_nx;
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign red_o  = rem_q[RED_OUT_W-1:0];

endmodule

// File: hw/rtl/cst_mul.sv
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Forms (a*b + 2^(F-1)) >> F, taking one 16-bit digit of b per cycle and
// then adding the rounding increment in a separate registered step.
// ----------------------------------------------------------------------------
module cst_mul import cst_pkg::*; #(
  parameter  int unsigned ACC_FRAC_BITS = ACC_FRAC_BITS_DEF,
  localparam int unsigned A_W = ACC_FRAC_BITS + TERM_IW,
  localparam int unsigned B_W = ACC_FRAC_BITS + X2_IW,
  localparam int unsigned R_W = ACC_FRAC_BITS + PROD_IW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  output logic           done_o,
  output logic [R_W-1:0] res_o
);

  localparam int unsigned ND  = (B_W + DIG_W - 1) / DIG_W;
  localparam int unsigned L_W = ND * DIG_W;
  localparam int unsigned C_W = $clog2(ND);

  logic           run_q;
  logic           rnd_q;
  logic           done_q;
  logic [C_W-1:0] cnt_q;
  logic [A_W-1:0] a_q;
  logic [L_W-1:0] b_q;
  logic [A_W-1:0] hi_q;
  logic [L_W-1:0] lo_q;
  logic [R_W-1:0] res_q;

  logic [DIG_W-1:0]     digit;
  logic [A_W+DIG_W-1:0] pp;
  logic [A_W+DIG_W-1:0] acc;
  logic [A_W+L_W-1:0]   prod;
  logic [R_W-1:0]       rounded;

  // Partial product of one digit, added to the running upper half
  assign digit   = b_q[DIG_W-1:0];
  assign pp      = a_q * digit;
  assign acc     = {{DIG_W{1'b0}}, hi_q} + pp;
  assign prod    = {hi_q, lo_q};
  assign rounded = R_W'(prod >> ACC_FRAC_BITS) + R_W'(prod[ACC_FRAC_BITS-1]);

  // Digit counter, rounding flag and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      rnd_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == C_W'(ND - 1)) begin
          run_q <= 1'b0;
          rnd_q <= 1'b1;
        end
      end else if (rnd_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // Load operands, shift product digits into the low half, round at the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= L_W'(b_i);
      hi_q <= '0;
      lo_q <= '0;
    end else if (run_q) begin
      b_q  <= b_q >> DIG_W;
      hi_q <= acc[A_W+DIG_W-1:DIG_W];
      lo_q <= {acc[DIG_W-1:0], lo_q[L_W-1:DIG_W]};
    end
    if (rnd_q) begin
      res_q <= rounded;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hw/rtl/cst_div.sv
// ----------------------------------------------------------------------------
// Small-divisor divider
// Restoring division of the term numerator by (2n-1)*2n, retiring four
// quotient bits per cycle on a narrow partial remainder.
// ----------------------------------------------------------------------------
module cst_div import cst_pkg::*; #(
  parameter  int unsigned ACC_FRAC_BITS = ACC_FRAC_BITS_DEF,
  parameter  int unsigned MAX_TERMS     = MAX_TERMS_DEF,
  localparam int unsigned N_W = ACC_FRAC_BITS + PROD_IW,
  localparam int unsigned D_W = $clog2((2 * MAX_TERMS - 1) * 2 * MAX_TERMS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic           done_o,
  output logic [N_W-1:0] quo_o
);

  localparam int unsigned NS  = (N_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned P_W = NS * DIV_BITS;
  localparam int unsigned C_W = $clog2(NS);

  logic           run_q;
  logic           done_q;
  logic [C_W-1:0] cnt_q;
  logic [P_W-1:0] num_q;
  logic [D_W-1:0] den_q;
  logic [D_W-1:0] rem_q;

  logic [P_W-1:0] num_nx;
  logic [D_W-1:0] rem_nx;
  logic [D_W:0]   trial;

  // Retire DIV_BITS quotient bits; the quotient shifts in behind the dividend
  always_comb begin
    num_nx = num_q;
    rem_nx = rem_q;
    trial  = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial  = {rem_nx, num_nx[P_W-1]};
      num_nx = {num_nx[P_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial     = trial - {1'b0, den_q};
        num_nx[0] = 1'b1;
      end
      rem_nx = trial[D_W-1:0];
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == C_W'(NS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands, then advance the remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= P_W'(num_i);
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= num_nx;
      rem_q <= rem_nx;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q[N_W-1:0];

endmodule

// File: hw/rtl/cosine_series_tolerance_top.sv
// ----------------------------------------------------------------------------
// Cosine by Maclaurin series with tolerance stop
// Reduces a Q16.16 angle modulo 2*pi and sums 1 - x^2/2! + x^4/4! - ...
// until a term falls to the tolerance or the term limit is reached.
// ----------------------------------------------------------------------------
// Pulse start with an angle beat while busy is low; busy stays high until the
// result appears on cosine_o, terms_used_o and limit_hit_o, which then hold
// it until the next result; done_o is high for exactly one cycle with it and
// cannot be held off. The range reduction, the multiplier and the divider run
// one after the other under the sequencer, and a new angle is taken in the
// cycle that shows the result. The user must write the tolerance register
// with tol_we_i only while busy is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cosine_series_tolerance_top import cst_pkg::*; #(
  parameter int unsigned MAX_TERMS     = MAX_TERMS_DEF,
  parameter int unsigned ACC_FRAC_BITS = ACC_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] angle_i,
  input  logic                      tol_we_i,
  input  logic [TOL_W-1:0]          tolerance_i,
  output logic                      done_o,
  output logic signed [COS_W-1:0]   cosine_o,
  output logic [TERMS_W-1:0]        terms_used_o,
  output logic                      limit_hit_o
);

  localparam int unsigned A_W   = ACC_FRAC_BITS + TERM_IW;
  localparam int unsigned B_W   = ACC_FRAC_BITS + X2_IW;
  localparam int unsigned R_W   = ACC_FRAC_BITS + PROD_IW;
  localparam int unsigned X_W   = ACC_FRAC_BITS + X_IW;
  localparam int unsigned SUM_W = ACC_FRAC_BITS + SUM_IW;
  localparam int unsigned N_W   = $clog2(MAX_TERMS + 1);
  localparam int unsigned D_W   = $clog2((2 * MAX_TERMS - 1) * 2 * MAX_TERMS + 1);
  localparam int unsigned CMP_W = A_W + TOL_W;
  localparam int unsigned O_W   = SUM_W + OUT_FRAC;

  cst_state_e state_q, state_d;
  logic [N_W-1:0]   n_q, n_d;
  logic             done_q, done_d;
  logic [TOL_W-1:0] tol_q;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [B_W-1:0]   x2_q, x2_d;
  logic             limit_q, limit_d;
  logic [COS_W-1:0] cosine_q;
  logic [N_W-1:0]   terms_q;
  logic             limit_out_q;

  // Unit hookup
  logic                 red_start, red_done;
  logic [ANGLE_W-1:0]   mag;
  logic [RED_OUT_W-1:0] red;
  logic                 mul_start, mul_done;
  logic [A_W-1:0]       mul_a;
  logic [B_W-1:0]       mul_b;
  logic [R_W-1:0]       mul_res;
  logic                 div_start, div_done;
  logic [R_W-1:0]       div_num;
  logic [R_W-1:0]       quo;

  logic [X_W-1:0]          x_conv;
  logic [N_W:0]            nn;
  logic [2*N_W+1:0]        den_full;
  logic [D_W-1:0]          den;
  logic [A_W-1:0]          term;
  logic signed [SUM_W-1:0] term_s;
  logic                    met;
  logic [SUM_W-1:0]        smag;
  logic [O_W-1:0]          smag_o;
  logic [COS_W-1:0]        cos_nx;

  // Magnitude of the angle; cosine is even
  assign mag = angle_i[ANGLE_W-1] ? ANGLE_W'(-angle_i) : angle_i;

  cst_red u_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .mag_i   (mag),
    .done_o  (red_done),
    .red_o   (red)
  );

  cst_mul #(
    .ACC_FRAC_BITS (ACC_FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  cst_div #(
    .ACC_FRAC_BITS (ACC_FRAC_BITS),
    .MAX_TERMS     (MAX_TERMS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Convert the Q32 remainder to the accumulator format
  if (ACC_FRAC_BITS < RED_FRAC) begin : g_x_rnd
    localparam int unsigned XD = RED_FRAC - ACC_FRAC_BITS;
    logic [RED_OUT_W:0] red_rnd;
    assign red_rnd = (RED_OUT_W + 1)'(red) + ((RED_OUT_W + 1)'(1) << (XD - 1));
    assign x_conv  = X_W'(red_rnd >> XD);
  end else begin : g_x_shl
    assign x_conv = X_W'(red) << (ACC_FRAC_BITS - RED_FRAC);
  end

  // Divisor (2n-1)*2n and its half for rounding
  assign nn       = {n_q, 1'b0};
  assign den_full = (2 * N_W + 2)'(nn - 1'b1) * (2 * N_W + 2)'(nn);
  assign den      = den_full[D_W-1:0];
  assign div_num  = mul_res + R_W'(den >> 1);

  // New term from the divider
  assign term   = quo[A_W-1:0];
  assign term_s = $signed(SUM_W'(term));

  // Tolerance test, aligned to the wider fraction
  if (ACC_FRAC_BITS >= TOL_FRAC) begin : g_met_up
    assign met = CMP_W'(term) <= (CMP_W'(tol_q) << (ACC_FRAC_BITS - TOL_FRAC));
  end else begin : g_met_dn
    assign met = (CMP_W'(term) << (TOL_FRAC - ACC_FRAC_BITS)) <= CMP_W'(tol_q);
  end

  // Output conversion: magnitude to Q1.30, rounding half away from zero
  assign smag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  if (ACC_FRAC_BITS > OUT_FRAC) begin : g_out_rnd
    localparam int unsigned OD = ACC_FRAC_BITS - OUT_FRAC;
    assign smag_o = (O_W'(smag) + (O_W'(1) << (OD - 1))) >> OD;
  end else if (ACC_FRAC_BITS < OUT_FRAC) begin : g_out_shl
    assign smag_o = O_W'(smag) << (OUT_FRAC - ACC_FRAC_BITS);
  end else begin : g_out_eq
    assign smag_o = O_W'(smag);
  end

  // Saturate to the 32-bit result
  always_comb begin
    if (sum_q[SUM_W-1]) begin
      if (smag_o >= O_W'(COS_MIN)) begin
        cos_nx = COS_MIN;
      end else begin
        cos_nx = ~smag_o[COS_W-1:0] + 1'b1;
      end
    end else begin
      if (smag_o > O_W'(COS_MAX)) begin
        cos_nx = COS_MAX;
      end else begin
        cos_nx = smag_o[COS_W-1:0];
      end
    end
  end

  // Sequencer: next state and unit starts
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    done_d    = 1'b0;
    sum_d     = sum_q;
    x2_d      = x2_q;
    limit_d   = limit_q;
    red_start = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          red_start = 1'b1;
          state_d   = ST_RED;
        end
      end
      ST_RED: begin
        if (red_done) begin
          mul_start = 1'b1;
          mul_a     = A_W'(x_conv);
          mul_b     = B_W'(x_conv);
          state_d   = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          x2_d      = B_W'(mul_res);
          sum_d     = $signed(SUM_W'(1) << ACC_FRAC_BITS);
          n_d       = N_W'(1);
          mul_start = 1'b1;
          mul_a     = A_W'(1) << ACC_FRAC_BITS;
          mul_b     = B_W'(mul_res);
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // Odd terms subtract, even terms add
          if (n_q[0]) begin
            sum_d = sum_q - term_s;
          end else begin
            sum_d = sum_q + term_s;
          end
          if (met || (n_q == N_W'(MAX_TERMS))) begin
            limit_d = !met;
            state_d = ST_OUT;
          end else begin
            n_d       = n_q + 1'b1;
            mul_start = 1'b1;
            mul_a     = term;
            mul_b     = x2_q;
            state_d   = ST_MUL;
          end
        end
      end
      ST_OUT: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers and the tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      done_q  <= 1'b0;
      tol_q   <= TOL_RESET;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      done_q  <= done_d;
      if (tol_we_i) begin
        tol_q <= tolerance_i;
      end
    end
  end

  // Datapath registers; hold the result until the next one
  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    x2_q    <= x2_d;
    limit_q <= limit_d;
    if (state_q == ST_OUT) begin
      cosine_q    <= cos_nx;
      terms_q     <= n_q;
      limit_out_q <= limit_q;
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign cosine_o     = $signed(cosine_q);
  assign terms_used_o = TERMS_W'(terms_q);
  assign limit_hit_o  = limit_out_q;

  // Result strobe lasts one cycle
  ap_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A result is shown only once the sequencer is free again
  ap_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Term count stays within one and the limit
  ap_terms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (terms_used_o != '0) && (terms_used_o <= TERMS_W'(MAX_TERMS)))
    else $error("terms_used out of range");

  // The limit flag only comes with a full term count
  ap_limit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && limit_hit_o) |-> (terms_used_o == TERMS_W'(MAX_TERMS)))
    else $error("limit_hit without full term count");

  // An accepted angle makes the block busy
  ap_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted angle did not start the sequencer");

endmodule

// File: tb/sv/tb_cosine_series_tolerance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine series block testbench
// Sends Q16.16 angles under several tolerance settings and checks each
// cosine, term count and limit flag against a fixed-point series computed here
// or typed in a row. A short table of edge cases runs first, then random angles.
// ----------------------------------------------------------------------------
module tb_cosine_series_tolerance_top;
  import cst_pkg::*;

  localparam int unsigned MAX_T = MAX_TERMS_DEF;
  localparam int unsigned FRAC  = ACC_FRAC_BITS_DEF;
  localparam logic [63:0] TWO_PI_FIX   = 64'h6_487E_D511;
  localparam logic [TOL_W-1:0] TOL_ONE = 31'h4000_0000;
  localparam int unsigned PHASE_BEATS  = 175;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [COS_W-1:0]   cosine;
    logic [TERMS_W-1:0] terms_used;
    logic               limit_hit;
  } cos_result_t;

  typedef struct packed {
    logic [TOL_W-1:0]   tol;
    logic [ANGLE_W-1:0] angle;
    logic               typed;
    cos_result_t        want;
  } angle_row_t;

  // Zero angle: the first term is zero, so one term and the sum stays 1.0
  localparam cos_result_t UNIT_RES = '{32'h4000_0000, 6'd1, 1'b0};
  localparam cos_result_t NO_RES   = '0;

  localparam int unsigned NUM_ROWS = 24;
  localparam angle_row_t DIR_ROWS [NUM_ROWS] = '{
    '{TOL_RESET, 32'h0000_0000, 1'b1, UNIT_RES},
    '{TOL_RESET, 32'h0000_0001, 1'b0, NO_RES},
    '{TOL_RESET, 32'hFFFF_FFFF, 1'b0, NO_RES},
    '{TOL_RESET, 32'h7FFF_FFFF, 1'b0, NO_RES},
    '{TOL_RESET, 32'h8000_0000, 1'b0, NO_RES},
    '{TOL_RESET, 32'h0001_0000, 1'b0, NO_RES},
    '{TOL_RESET, 32'hFFFF_0000, 1'b0, NO_RES},
    '{TOL_RESET, 32'h0003_243F, 1'b0, NO_RES},
    '{TOL_RESET, 32'hFFFC_DBC1, 1'b0, NO_RES},
    '{TOL_RESET, 32'h0006_487F, 1'b0, NO_RES},
    '{TOL_RESET, 32'h0006_487E, 1'b0, NO_RES},
    '{TOL_RESET, 32'h0001_921F, 1'b0, NO_RES},
    '{TOL_RESET, 32'h0004_0000, 1'b0, NO_RES},
    '{TOL_RESET, 32'h7FFF_0000, 1'b0, NO_RES},
    '{31'd0,     32'h0000_0000, 1'b1, UNIT_RES},
    '{31'd0,     32'h0003_243F, 1'b0, NO_RES},
    '{31'd0,     32'h0001_0000, 1'b0, NO_RES},
    '{31'd0,     32'h7FFF_FFFF, 1'b0, NO_RES},
    '{TOL_ONE,   32'h0000_0000, 1'b1, UNIT_RES},
    '{TOL_ONE,   32'h0001_0000, 1'b0, NO_RES},
    '{TOL_ONE,   32'h0005_A000, 1'b0, NO_RES},
    '{TOL_ONE,   32'h8000_0000, 1'b0, NO_RES},
    '{31'd1,     32'h0003_243F, 1'b0, NO_RES},
    '{31'd1,     32'h0001_921F, 1'b0, NO_RES}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic signed [ANGLE_W-1:0] angle_i;
  logic                      tol_we_i;
  logic [TOL_W-1:0]          tolerance_i;
  logic                      done_o;
  logic signed [COS_W-1:0]   cosine_o;
  logic [TERMS_W-1:0]        terms_used_o;
  logic                      limit_hit_o;

  cos_result_t      pending_cos_q [$];
  cos_result_t      want_res;
  logic [TOL_W-1:0] cur_tol;
  int unsigned      mismatch_cnt;

  cosine_series_tolerance_top #(
    .MAX_TERMS     (MAX_T),
    .ACC_FRAC_BITS (FRAC)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .angle_i      (angle_i),
    .tol_we_i     (tol_we_i),
    .tolerance_i  (tolerance_i),
    .done_o       (done_o),
    .cosine_o     (cosine_o),
    .terms_used_o (terms_used_o),
    .limit_hit_o  (limit_hit_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // (a*b + half) >> s, low 64 bits kept
  function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + (128'd1 << (s - 1));
    prod = prod >> s;
    return prod[63:0];
  endfunction

  // Reduce the angle, sum the series, round and saturate to Q1.30
  function automatic cos_result_t cosine_series(input logic [ANGLE_W-1:0] raw,
                                                input logic [TOL_W-1:0] tol);
    logic [31:0]        neg_raw;
    logic [63:0]        mag, red, x, x2, term, divisor, smag;
    logic signed [63:0] sum_acc;
    int                 d, od;
    int unsigned        n, used;
    logic               met, neg;
    cos_result_t        res;
    neg_raw = ~raw + 32'd1;
    mag = raw[31] ? {32'd0, neg_raw} : {32'd0, raw};
    red = (mag << ANGLE_FRAC) % TWO_PI_FIX;
    d = 32 - int'(FRAC);
    if (d > 0) x = (red + (64'd1 << (d - 1))) >> d;
    else       x = red << (-d);
    x2 = mul_round(x, x, FRAC);
    sum_acc = 64'sd1 <<< FRAC;
    term = 64'd1 << FRAC;
    used = 0;
    met = 1'b0;
    n = 1;
    // Advance one term at a time until tolerance or the term limit
    while (!met && n <= MAX_T) begin
      divisor = 64'(2 * n - 1) * 64'(2 * n);
      term = mul_round(term, x2, FRAC);
      term = (term + divisor / 2) / divisor;
      if (n[0]) sum_acc = sum_acc - $signed(term);
      else      sum_acc = sum_acc + $signed(term);
      used = n;
      if (FRAC >= 30) met = term <= ({33'd0, tol} << (FRAC - 30));
      else            met = (term << (30 - FRAC)) <= {33'd0, tol};
      n++;
    end
    neg = sum_acc < 0;
    smag = neg ? 64'd0 - 64'(sum_acc) : 64'(sum_acc);
    od = int'(FRAC) - 30;
    if (od > 0)      smag = (smag + (64'd1 << (od - 1))) >> od;
    else if (od < 0) smag = smag << (-od);
    if (neg) res.cosine = (smag >= 64'h8000_0000) ? COS_MIN : 32'd0 - smag[31:0];
    else     res.cosine = (smag > 64'h7FFF_FFFF) ? COS_MAX : smag[31:0];
    res.terms_used = used[TERMS_W-1:0];
    res.limit_hit  = !met;
    return res;
  endfunction

  // Random angle: raw bits most often, then small angles, near multiples of pi, extremes
  function automatic logic [ANGLE_W-1:0] rand_angle();
    logic [ANGLE_W-1:0] a;
    int unsigned        k;
    case ($urandom_range(9))
      0, 1, 2, 3: a = $urandom;
      4, 5, 6:    a = $urandom_range(0, 32'h7_FFFF);
      7: begin
        k = $urandom_range(0, 5000);
        a = k * 411775 + $urandom_range(0, 8) - 4;
      end
      8: begin
        k = $urandom_range(0, 5000);
        a = (2 * k + 1) * 205887 + $urandom_range(0, 8) - 4;
      end
      default: begin
        case ($urandom_range(3))
          0:       a = 32'h7FFF_FFFF;
          1:       a = 32'h8000_0000;
          2:       a = 32'h0000_0000;
          default: a = 32'h0000_0001;
        endcase
      end
    endcase
    if ($urandom_range(1)) a = ~a + 32'd1;
    return a;
  endfunction

  // Random tolerance spread over every magnitude
  function automatic logic [TOL_W-1:0] rand_tol();
    int unsigned k;
    k = $urandom_range(0, 30);
    return TOL_W'($urandom_range(1, 32'd1 << k));
  endfunction

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_cos_q.size() == 0) begin
        $error("result beat with nothing pending: cosine %h", cosine_o);
        mismatch_cnt++;
      end else begin
        want_res = pending_cos_q.pop_front();
        if (cosine_o !== want_res.cosine) begin
          $error("cosine mismatch: expected %h, got %h", want_res.cosine, cosine_o);
          mismatch_cnt++;
        end
        if (terms_used_o !== want_res.terms_used) begin
          $error("terms_used mismatch: expected %0d, got %0d", want_res.terms_used,
                 terms_used_o);
          mismatch_cnt++;
        end
        if (limit_hit_o !== want_res.limit_hit) begin
          $error("limit_hit mismatch: expected %b, got %b", want_res.limit_hit,
                 limit_hit_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Hold start low until every pending result is back and the block is idle
  task automatic drain_results();
    start <= 1'b0;
    while (pending_cos_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_tolerance(input logic [TOL_W-1:0] val);
    tol_we_i    <= 1'b1;
    tolerance_i <= val;
    cur_tol = val;
    @(posedge clk_i);
    tol_we_i <= 1'b0;
  endtask

  // Idle at random, then hold an angle beat until it is taken
  task automatic issue_angle(input logic [ANGLE_W-1:0] a, input logic typed,
                             input cos_result_t typed_res, input int unsigned idle_pct);
    if (idle_pct != 0 && $urandom_range(15) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 350)) @(posedge clk_i);
    end
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    angle_i <= a;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_cos_q.push_back(typed ? typed_res : cosine_series(a, cur_tol));
  endtask

  initial begin
    int unsigned      ph, i, idle_pct;
    logic [TOL_W-1:0] ph_tol;
    rst_ni       = 1'b0;
    start        = 1'b0;
    angle_i      = '0;
    tol_we_i     = 1'b0;
    tolerance_i  = TOL_RESET;
    cur_tol      = TOL_RESET;
    mismatch_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Edge cases from the table, reloading the tolerance where a row asks
    for (i = 0; i < NUM_ROWS; i++) begin
      if (DIR_ROWS[i].tol != cur_tol) begin
        drain_results();
        load_tolerance(DIR_ROWS[i].tol);
      end
      issue_angle(DIR_ROWS[i].angle, DIR_ROWS[i].typed, DIR_ROWS[i].want, 0);
    end

    // Random angles, one tolerance and one idle rate per phase
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1:       ph_tol = '0;
        2:       ph_tol = TOL_ONE;
        3:       ph_tol = 31'd1;
        5:       ph_tol = TOL_RESET;
        default: ph_tol = rand_tol();
      endcase
      case (ph % 4)
        1:       idle_pct = 71;
        3:       idle_pct = 38;
        default: idle_pct = 0;
      endcase
      drain_results();
      load_tolerance(ph_tol);
      for (i = 0; i < PHASE_BEATS; i++) issue_angle(rand_angle(), 1'b0, NO_RES, idle_pct);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cos_q.size() == 0) begin
      $display("cosine_series_tolerance_top test passed");
    end else begin
      $display("cosine_series_tolerance_top test failed");
    end
    $finish;
  end

  // Give up long after the slowest correct run would have ended
  initial begin
    #20_000_000;
    $display("cosine_series_tolerance_top test failed");
    $finish;
  end

endmodule
